### design/pwpf_pkg.sv
// ----------------------------------------------------------------------------
// pwpf_pkg: shared constants and types for the plane-wave phase factor block
// Arctangent table, CORDIC gain, phase constant, register indexes and the
// classified item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package pwpf_pkg;

  localparam int unsigned MaxAnglesDefault = 1024;
  localparam int unsigned CordicSteps      = 30;
  localparam logic [31:0] CordicGain       = 32'd652032874;
  localparam logic [31:0] PhaseC           = 32'd683565276;
  localparam logic [31:0] WavenumberReset  = 32'd65536;
  localparam logic [31:0] CellAreaReset    = 32'd65536;
  localparam logic [10:0] AngleCountReset  = 11'd1;

  localparam logic [1:0] RegWavenumber = 2'd0;
  localparam logic [1:0] RegCellArea   = 2'd1;
  localparam logic [1:0] RegAngleCount = 2'd2;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned AngleW  = 32;
  localparam int unsigned CordW   = 34;
  localparam int unsigned QueueDepth = 4;

  // Item after classification in the front end.
  typedef struct packed {
    logic                     disagg;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [IndexW-1:0]        idx;
  } item_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
        27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

### design/pwpf_cordic.sv
// ----------------------------------------------------------------------------
// pwpf_cordic: pipelined rotation-mode CORDIC on a binary angle
// One micro-rotation per stage, quarter turn applied at the output. Carries a
// side payload of SideW bits alongside the angle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwpf_cordic #(
  parameter int unsigned SideW = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [31:0]          angle_i,
  input  wire logic [SideW-1:0]     side_i,
  output logic                      valid_o,
  output logic signed [pwpf_pkg::CordW-1:0] cos_o,
  output logic signed [pwpf_pkg::CordW-1:0] sin_o,
  output logic [SideW-1:0]          side_o
);
  localparam int unsigned N = pwpf_pkg::CordicSteps;
  localparam int unsigned W = pwpf_pkg::CordW;

  logic                valid_q [N+1];
  logic signed [W-1:0] x_q     [N+1];
  logic signed [W-1:0] y_q     [N+1];
  logic signed [W-1:0] z_q     [N+1];
  logic [1:0]          quad_q  [N+1];
  logic [SideW-1:0]    side_q  [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i <= N; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int unsigned i = 0; i < N; i++) valid_q[i+1] <= valid_q[i];
    end
  end

  // Stage 0 loads the start vector; each later stage does one micro-rotation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= W'(pwpf_pkg::CordicGain);
      y_q[0]    <= '0;
      z_q[0]    <= W'({2'b00, angle_i[29:0]});
      quad_q[0] <= angle_i[31:30];
      side_q[0] <= side_i;
      for (int unsigned i = 0; i < N; i++) begin
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - W'(pwpf_pkg::atan_turn(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + W'(pwpf_pkg::atan_turn(i));
        end
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    case (quad_q[N])
      2'd0: begin cos_o = x_q[N];  sin_o = y_q[N];  end
      2'd1: begin cos_o = -y_q[N]; sin_o = x_q[N];  end
      2'd2: begin cos_o = -x_q[N]; sin_o = -y_q[N]; end
      default: begin cos_o = y_q[N]; sin_o = -x_q[N]; end
    endcase
  end

  assign valid_o = valid_q[N];
  assign side_o  = side_q[N];
endmodule
`default_nettype wire

### design/pwpf_front.sv
// ----------------------------------------------------------------------------
// pwpf_front: input stage
// Accepts a beat, forms the exact point offset and registers the item.
// ----------------------------------------------------------------------------
`default_nettype none
module pwpf_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic                   action_i,
  input  wire logic signed [31:0]     point_x_i,
  input  wire logic signed [31:0]     point_y_i,
  input  wire logic signed [31:0]     center_x_i,
  input  wire logic signed [31:0]     center_y_i,
  input  wire logic [9:0]             direction_index_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output pwpf_pkg::item_t             item_o
);
  logic            valid_q;
  pwpf_pkg::item_t item_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q.disagg <= action_i;
      item_q.dx     <= 33'(point_x_i) - 33'(center_x_i);
      item_q.dy     <= 33'(point_y_i) - 33'(center_y_i);
      item_q.idx    <= direction_index_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

### design/pwpf_queue.sv
// ----------------------------------------------------------------------------
// pwpf_queue: small register FIFO between front and back end
// ----------------------------------------------------------------------------
`default_nettype none
module pwpf_queue #(
  parameter int unsigned Depth = pwpf_pkg::QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  pwpf_pkg::item_t   item_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output pwpf_pkg::item_t   item_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pwpf_pkg::item_t   mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  logic              push, pop;

  assign ready_o = (cnt_q != (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end
endmodule
`default_nettype wire

### design/pwpf_back.sv
// ----------------------------------------------------------------------------
// pwpf_back: arithmetic pipeline
// Direction angle by reciprocal multiply, direction CORDIC, projection,
// phase, phase CORDIC, output scaling and saturation. The whole pipeline
// advances on one enable and holds while the output register waits.
// ----------------------------------------------------------------------------
`default_nettype none
module pwpf_back #(
  parameter int unsigned MaxAngles = pwpf_pkg::MaxAnglesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [31:0]        wavenumber_i,
  input  wire logic [31:0]        cell_area_i,
  input  wire logic [10:0]        angle_count_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  pwpf_pkg::item_t         item_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [31:0]             real_o,
  output logic [31:0]             imag_o
);
  localparam int unsigned CW = pwpf_pkg::CordW;
  localparam int unsigned MaxW = $clog2(MaxAngles + 1);
  localparam int unsigned NW = (MaxW > 11) ? MaxW : 11;
  localparam int unsigned SideD = 1 + 2 * pwpf_pkg::DiffW;

  // Effective count and its reciprocal, rebuilt after reset and whenever angle_count changes.
  logic [NW-1:0]   n_eff;
  logic [NW-1:0]   n_q;
  logic [63:0]     rec_q;    // floor((2^64-1) / n), computed serially
  logic [64:0]     rem_q;
  logic [64:0]     r2;
  logic [6:0]      bit_q;
  logic            rec_busy_q;
  logic [10:0]     cnt_seen_q;
  logic            cnt_stale;

  always_comb begin
    n_eff = NW'(angle_count_i);
    if (angle_count_i == '0) n_eff = NW'(1);
    if (NW'(angle_count_i) > NW'(MaxAngles)) n_eff = NW'(MaxAngles);
  end

  assign cnt_stale = (angle_count_i != cnt_seen_q);
  assign r2        = {rem_q[63:0], 1'b1};

  // Restoring division of 2^64-1 by n, one bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_busy_q <= 1'b1;
      bit_q      <= 7'd64;
      rem_q      <= '0;
      rec_q      <= '0;
      n_q        <= NW'(1);
      cnt_seen_q <= pwpf_pkg::AngleCountReset;
    end else if (cnt_stale) begin
      cnt_seen_q <= angle_count_i;
      rec_busy_q <= 1'b1;
      bit_q      <= 7'd64;
      rem_q      <= '0;
      rec_q      <= '0;
      n_q        <= n_eff;
    end else if (rec_busy_q) begin
      if (r2 >= 65'(n_q)) begin
        rem_q <= r2 - 65'(n_q);
        rec_q <= {rec_q[62:0], 1'b1};
      end else begin
        rem_q <= r2;
        rec_q <= {rec_q[62:0], 1'b0};
      end
      bit_q <= bit_q - 7'd1;
      if (bit_q == 7'd1) rec_busy_q <= 1'b0;
    end
  end
  // recp = ceil(2^64 / n) mod 2^64; its error times idx < 2^10 stays far below
  // the 1/n margin, so (idx * recp) >> 32 gives floor(idx * 2^32 / n) mod 2^32.

  // Pipeline enable: hold everything while the output beat waits.
  logic en;
  logic out_v_q;
  logic [31:0] out_re_q, out_im_q;

  assign en      = !out_v_q || ready_i;
  assign ready_o = en && !rec_busy_q && !cnt_stale;

  // ---- stage A: direction angle partial products (10x32 each) ----
  logic          a_v_q;
  logic [41:0]   a_plo_q;
  logic [31:0]   a_phi_q;
  logic [SideD-1:0] a_side_q;
  logic [63:0]   recp;
  assign recp = rec_q + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  a_v_q <= 1'b0;
    else if (en)  a_v_q <= valid_i && ready_o;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_plo_q  <= 42'(item_i.idx) * 42'(recp[31:0]);
      a_phi_q  <= 32'(42'(item_i.idx) * 42'(recp[63:32]));
      a_side_q <= {item_i.disagg, item_i.dx, item_i.dy};
    end
  end

  logic          b_v_q;
  logic [31:0]   b_dir_q;
  logic [SideD-1:0] b_side_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  b_v_q <= 1'b0;
    else if (en)  b_v_q <= a_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_dir_q  <= a_phi_q + 32'(a_plo_q[41:32]);
      b_side_q <= a_side_q;
    end
  end

  // ---- direction CORDIC ----
  logic c_v;
  logic signed [CW-1:0] ux, uy;
  logic [SideD-1:0] c_side;
  pwpf_cordic #(.SideW(SideD)) u_dir (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_v_q), .angle_i(b_dir_q),
    .side_i(b_side_q), .valid_o(c_v), .cos_o(ux), .sin_o(uy), .side_o(c_side)
  );

  // ---- projection products ----
  logic d_v_q, d_dis_q;
  logic signed [66:0] d_px_q, d_py_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  d_v_q <= 1'b0;
    else if (en)  d_v_q <= c_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_dis_q <= c_side[SideD-1];
      d_px_q  <= 67'(ux) * 67'($signed(c_side[2*pwpf_pkg::DiffW-1:pwpf_pkg::DiffW]));
      d_py_q  <= 67'(uy) * 67'($signed(c_side[pwpf_pkg::DiffW-1:0]));
    end
  end

  logic e_v_q, e_dis_q;
  logic [63:0] e_proj_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  e_v_q <= 1'b0;
    else if (en)  e_v_q <= d_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_dis_q  <= d_dis_q;
      e_proj_q <= 64'(d_px_q >>> 30) + 64'(d_py_q >>> 30);
    end
  end

  // proj * wavenumber mod 2^64 (32x32 partial products over two stages)
  logic f_v_q, f_dis_q;
  logic [63:0] f_lo_q, f_hi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  f_v_q <= 1'b0;
    else if (en)  f_v_q <= e_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_dis_q <= e_dis_q;
      f_lo_q  <= 64'(e_proj_q[31:0]) * 64'(wavenumber_i);
      f_hi_q  <= 64'(e_proj_q[63:32]) * 64'(wavenumber_i);
    end
  end

  logic g_v_q, g_dis_q;
  logic [63:0] g_pw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  g_v_q <= 1'b0;
    else if (en)  g_v_q <= f_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_dis_q <= f_dis_q;
      g_pw_q  <= f_lo_q + {f_hi_q[31:0], 32'd0};
    end
  end

  // pw * PhaseC mod 2^64, take bits 63:32
  logic h_v_q, h_dis_q;
  logic [63:0] h_lo_q;
  logic [31:0] h_hi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  h_v_q <= 1'b0;
    else if (en)  h_v_q <= g_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_dis_q <= g_dis_q;
      h_lo_q  <= 64'(g_pw_q[31:0]) * 64'(pwpf_pkg::PhaseC);
      h_hi_q  <= 32'(64'(g_pw_q[63:32]) * 64'(pwpf_pkg::PhaseC));
    end
  end

  logic i_v_q, i_dis_q;
  logic [31:0] i_ph_q;
  logic [31:0] ph;
  assign ph = h_lo_q[63:32] + h_hi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  i_v_q <= 1'b0;
    else if (en)  i_v_q <= h_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      i_dis_q <= h_dis_q;
      i_ph_q  <= h_dis_q ? ph : (32'd0 - ph);
    end
  end

  // ---- phase CORDIC ----
  logic j_v, j_dis;
  logic signed [CW-1:0] cs, sn;
  pwpf_cordic #(.SideW(1)) u_ph (
    .clk_i, .rst_ni, .en_i(en), .valid_i(i_v_q), .angle_i(i_ph_q),
    .side_i(i_dis_q), .valid_o(j_v), .cos_o(cs), .sin_o(sn), .side_o(j_dis)
  );

  // ---- scaling ----
  logic k_v_q;
  logic signed [CW+33-1:0] k_re_q, k_im_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  k_v_q <= 1'b0;
    else if (en)  k_v_q <= j_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (j_dis) begin
        k_re_q <= (CW+33)'(cs) <<< 16;
        k_im_q <= (CW+33)'(sn) <<< 16;
      end else begin
        k_re_q <= (CW+33)'(cs) * (CW+33)'($signed({1'b0, cell_area_i}));
        k_im_q <= (CW+33)'(sn) * (CW+33)'($signed({1'b0, cell_area_i}));
      end
    end
  end

  function automatic logic [31:0] sat(input logic signed [CW+33-1:0] v);
    logic signed [CW+33-1:0] s;
    begin
      s = v >>> 30;
      if (s > (CW+33)'(64'sd2147483647)) return 32'h7FFFFFFF;
      if (s < -(CW+33)'(64'sd2147483648)) return 32'h80000000;
      return s[31:0];
    end
  endfunction

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  out_v_q <= 1'b0;
    else if (en)  out_v_q <= k_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q <= sat(k_re_q);
      out_im_q <= sat(k_im_q);
    end
  end

  assign valid_o = out_v_q;
  assign real_o  = out_re_q;
  assign imag_o  = out_im_q;
endmodule
`default_nettype wire

### design/plane_wave_phase_factor.sv
// Throughput: one beat per cycle; the pipeline holds while an output beat
// waits, and s_axis_tready drops once the front register and queue are full.
// After reset, and from the cycle after each angle_count write that changes the
// value, a serial reciprocal computation holds the back end.
// Registers reset to wavenumber 1.0, cell_area 1.0, angle_count 1.
// ----------------------------------------------------------------------------
// plane_wave_phase_factor: top level
// Stream in, stream out, configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none
module plane_wave_phase_factor #(
  parameter int unsigned MaxAngles = pwpf_pkg::MaxAnglesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point_x, point_y, center_x, center_y, direction_index (lowest first)
  input  wire logic [143:0] s_axis_tdata,
  // action
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // real_part, imag_part (lowest first)
  output logic [63:0]       m_axis_tdata
);
  logic [31:0] wave_q, area_q;
  logic [10:0] cnt_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= pwpf_pkg::WavenumberReset;
      area_q <= pwpf_pkg::CellAreaReset;
      cnt_q  <= pwpf_pkg::AngleCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwpf_pkg::RegWavenumber: wave_q <= cfg_data_i;
        pwpf_pkg::RegCellArea:   area_q <= cfg_data_i;
        pwpf_pkg::RegAngleCount: cnt_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic            f_v, f_r, q_v, q_r;
  pwpf_pkg::item_t f_item, q_item;

  pwpf_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .action_i(s_axis_tuser),
    .point_x_i(s_axis_tdata[31:0]), .point_y_i(s_axis_tdata[63:32]),
    .center_x_i(s_axis_tdata[95:64]), .center_y_i(s_axis_tdata[127:96]),
    .direction_index_i(s_axis_tdata[137:128]),
    .valid_o(f_v), .ready_i(f_r), .item_o(f_item)
  );

  pwpf_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_v), .ready_o(f_r), .item_i(f_item),
    .valid_o(q_v), .ready_i(q_r), .item_o(q_item)
  );

  pwpf_back #(.MaxAngles(MaxAngles)) u_back (
    .clk_i, .rst_ni,
    .wavenumber_i(wave_q), .cell_area_i(area_q), .angle_count_i(cnt_q),
    .valid_i(q_v), .ready_o(q_r), .item_i(q_item),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .real_o(m_axis_tdata[31:0]), .imag_o(m_axis_tdata[63:32])
  );
endmodule
`default_nettype wire

### sim/pwpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpf_checker: phase factor predictor and result comparator
// Watches the configuration, input and output channels of the block, keeps
// its own register copy, works out the complex phase factor of every input
// beat and compares each output beat against the oldest pending factor.
// ----------------------------------------------------------------------------
module pwpf_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [143:0] s_data_i,
  input  logic         s_user_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [63:0]  m_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  localparam longint GainQ30 = 652032874;
  localparam longint TwoPiInv = 683565276;
  localparam int unsigned AngleLimit = 1024;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } factor_t;

  factor_t factor_q [$];
  logic [31:0] wave_k;
  logic [31:0] area_k;
  logic [10:0] count_k;
  int          fails;

  longint turn_step [0:29] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  assign fail_count_o = fails;
  assign pending_o    = factor_q.size();

  // Rotate (gain, 0) by a binary angle; quarter turn applied exactly.
  function automatic void rotate_turn(input logic [31:0] a, output longint cs,
                                      output longint sn);
    longint x, y, z, nx;
    x = GainQ30;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - turn_step[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + turn_step[i];
      end
      x = nx;
    end
    case (a[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic factor_t phase_factor(input logic [143:0] d, input logic disagg);
    logic signed [31:0] px, py, cx, cy;
    logic [9:0]         idx;
    longint             dx, dy, ux, uy, proj, c, s;
    longint unsigned    n, dir_w, prod;
    logic [31:0]        ph;
    factor_t            f;
    px  = d[31:0];
    py  = d[63:32];
    cx  = d[95:64];
    cy  = d[127:96];
    idx = d[137:128];
    dx  = longint'(px) - longint'(cx);
    dy  = longint'(py) - longint'(cy);
    n   = count_k;
    if (n == 0) n = 1;
    if (n > AngleLimit) n = AngleLimit;
    dir_w = (longint'(idx) << 32) / n;
    rotate_turn(dir_w[31:0], ux, uy);
    proj = ((ux * dx) >>> 30) + ((uy * dy) >>> 30);
    prod = proj * longint'({32'd0, wave_k}) * TwoPiInv;
    ph   = prod[63:32];
    if (!disagg) ph = -ph;
    rotate_turn(ph, c, s);
    if (disagg) begin
      f.re = clamp32(c >>> 14);
      f.im = clamp32(s >>> 14);
    end else begin
      f.re = clamp32((c * longint'({32'd0, area_k})) >>> 30);
      f.im = clamp32((s * longint'({32'd0, area_k})) >>> 30);
    end
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    factor_t want;
    logic signed [31:0] got_re, got_im;
    if (!rst_ni) begin
      wave_k  <= 32'd65536;
      area_k  <= 32'd65536;
      count_k <= 11'd1;
      factor_q.delete();
      fails   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pwpf_pkg::RegWavenumber: wave_k  <= cfg_data_i;
          pwpf_pkg::RegCellArea:   area_k  <= cfg_data_i;
          pwpf_pkg::RegAngleCount: count_k <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) factor_q.push_back(phase_factor(s_data_i, s_user_i));
      if (m_valid_i && m_ready_i) begin
        got_re = m_data_i[31:0];
        got_im = m_data_i[63:32];
        if (factor_q.size() == 0) begin
          if (fails < 10) $display("[%0t] unexpected output beat re=%0d im=%0d",
                                   $realtime, got_re, got_im);
          fails <= fails + 1;
        end else begin
          want = factor_q.pop_front();
          if (want.re !== got_re || want.im !== got_im) begin
            if (fails < 10)
              $display("[%0t] mismatch: re exp %0d got %0d, im exp %0d got %0d",
                       $realtime, want.re, got_re, want.im, got_im);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: plane-wave phase factor regression
// Drives register settings and point/centre/direction beats with random
// gaps and output back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 120;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           beats_sent = 0;
  int           settings_used = 0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  logic [10:0]  count_now = 11'd1;

  logic [31:0] wave_set [8] = '{32'h00010000, 32'hFFFFFFFF, 32'h0, 32'h00032000,
                                32'h00000001, 32'h80000000, 32'h0000C000, 32'h00250000};
  logic [31:0] area_set [8] = '{32'h00010000, 32'hFFFFFFFF, 32'h0, 32'h00004000,
                                32'h80000000, 32'h00000001, 32'h00020000, 32'h00000400};
  logic [10:0] count_set [8] = '{11'd1024, 11'd2047, 11'd7, 11'd64,
                                 11'd0, 11'd360, 11'd1, 11'd1000};

  always #6 clk_i = ~clk_i;

  plane_wave_phase_factor u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  pwpf_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_valid_i(s_tvalid), .s_ready_i(s_tready), .s_data_i(s_tdata),
    .s_user_i(s_tuser),
    .m_valid_i(m_tvalid), .m_ready_i(m_tready), .m_data_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d factors pending", pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: per-beat stall, plus a long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // Drop the input and wait until every expected result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    if (idx == pwpf_pkg::RegAngleCount) count_now = val[10:0];
  endtask

  task automatic apply_setting(input logic [31:0] wave, input logic [31:0] area,
                               input logic [10:0] count);
    drain();
    write_reg(pwpf_pkg::RegWavenumber, wave);
    write_reg(pwpf_pkg::RegCellArea, area);
    write_reg(pwpf_pkg::RegAngleCount, {21'd0, count});
    settings_used++;
  endtask

  task automatic send_beat(input logic act, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [9:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'd0, idx, cy, cx, py, px};
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
  endtask

  function automatic logic [31:0] coord();
    // Mostly a few units around the origin, sometimes anywhere.
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h00100000) - 32'h00080000;
  endfunction

  task automatic random_beat();
    logic [9:0] idx;
    int unsigned n;
    n = (count_now == 0) ? 1 : (count_now > 1024 ? 1024 : count_now);
    if ($urandom_range(0, 7) == 0) idx = 10'($urandom());
    else idx = 10'($urandom_range(0, n - 1));
    send_beat(1'($urandom()), coord(), coord(), coord(), coord(), idx);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, then coordinate and index extremes.
    send_beat(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0);
    send_beat(1'b1, 32'h00010000, 32'h0, 32'h0, 32'h0, 10'd0);
    apply_setting(32'h00010000, 32'h00010000, 11'd8);
    for (int i = 0; i < 8; i++)
      send_beat(i[0], 32'h00018000, 32'hFFFF0000, 32'h0, 32'h00004000, i[9:0]);
    send_beat(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 10'd1);
    send_beat(1'b1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 10'd3);
    send_beat(1'b1, 32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 10'd1023);
    send_beat(1'b0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 10'd9);
    // Zero count acts as one; a count above the limit is clipped.
    apply_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 11'd0);
    send_beat(1'b0, 32'h12345678, 32'h9ABCDEF0, 32'h0, 32'h0, 10'd5);
    send_beat(1'b1, 32'h00020000, 32'hFFFE0000, 32'h00010000, 32'h0, 10'd0);
    apply_setting(32'h0, 32'h0, 11'd2047);
    send_beat(1'b0, 32'h00030000, 32'h00050000, 32'h0, 32'h0, 10'd1023);
    send_beat(1'b1, 32'h00030000, 32'h00050000, 32'h0, 32'h0, 10'd512);

    // Random phases over several register settings.
    for (int p = 0; p < 8; p++) begin
      apply_setting(wave_set[p], area_set[p], count_set[p]);
      no_idle = (p == 3);
      for (int k = 0; k < 220; k++) begin
        if (p == 2 && k == 20) hold_req = 1'b1;
        if (p == 5 && k == 110) drain();
        random_beat();
      end
    end
    no_idle = 1'b0;
    drain();

    $display("%0d input beats over %0d register settings, both actions,", beats_sent,
             settings_used);
    $display("zero and clipped angle counts, long output stall and input pause");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### plane_wave_phase_factor.f
design/pwpf_pkg.sv
design/pwpf_cordic.sv
design/pwpf_front.sv
design/pwpf_queue.sv
design/pwpf_back.sv
design/plane_wave_phase_factor.sv
sim/pwpf_checker.sv
sim/tb_top.sv
